// ----- src/tgr_pkg.sv -----
// Shared types and constants of the tile grid rotate engine.
// No dependencies; every other file of the block refers to this package.
package tgr_pkg;

    // Fixed field widths
    localparam int SIDE_W     = 5;
    localparam int AREA_W     = 2 * SIDE_W;
    localparam int COLOR_W    = 3;
    localparam int OP_W       = 3;
    localparam int CFG_ADDR_W = 1;

    // Operation codes carried by an input item
    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 3'd0,
        OP_READ     = 3'd1,
        OP_FLOOD    = 3'd2,
        OP_ROT_CW   = 3'd3,
        OP_ROT_CCW  = 3'd4,
        OP_SPIN_CW  = 3'd5,
        OP_SPIN_CCW = 3'd6,
        OP_SOLVED   = 3'd7
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FACE_WIDTH  = 1'd0,
        REG_FACE_HEIGHT = 1'd1
    } t_cfg_reg;

    // Kind of grid turn
    typedef enum logic [1:0] {
        TURN_HALF = 2'd0,
        TURN_CW   = 2'd1,
        TURN_CCW  = 2'd2
    } t_turn;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ACCESS,
        ST_RD_WAIT,
        ST_FLOOD,
        ST_TURN_INIT,
        ST_TURN,
        ST_TURN_END,
        ST_SCAN,
        ST_SCAN_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [SIDE_W-1:0]  col;
        logic [SIDE_W-1:0]  row;
        logic [COLOR_W-1:0] color;
    } t_item;

    typedef struct packed {
        logic [COLOR_W-1:0] read_color;
        logic               solved;
        logic [SIDE_W-1:0]  cur_width;
        logic [SIDE_W-1:0]  cur_height;
        logic               status;
    } t_result;

endpackage

// ----- src/tgr_if.sv -----
// Valid/ready channel interfaces of the tile grid rotate engine.
// Depends on tgr_pkg for the field widths.
interface tgr_in_if;
    logic                       valid;
    logic                       ready;
    logic [tgr_pkg::OP_W-1:0]    op;
    logic [tgr_pkg::SIDE_W-1:0]  col;
    logic [tgr_pkg::SIDE_W-1:0]  row;
    logic [tgr_pkg::COLOR_W-1:0] color;

    modport source (output valid, output op, output col, output row, output color,
                    input ready);
    modport sink   (input valid, input op, input col, input row, input color,
                    output ready);
endinterface

interface tgr_out_if;
    logic                        valid;
    logic                        ready;
    logic [tgr_pkg::COLOR_W-1:0] read_color;
    logic                        solved;
    logic [tgr_pkg::SIDE_W-1:0]  cur_width;
    logic [tgr_pkg::SIDE_W-1:0]  cur_height;
    logic                        status;

    modport source (output valid, output read_color, output solved, output cur_width,
                    output cur_height, output status, input ready);
    modport sink   (input valid, input read_color, input solved, input cur_width,
                    input cur_height, input status, output ready);
endinterface

interface tgr_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tgr_pkg::CFG_ADDR_W-1:0] addr;
    logic [tgr_pkg::SIDE_W-1:0]     data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

// ----- src/tile_grid_rotate_engine.sv -----
// Top level of the tile grid rotate engine: configuration registers, size
// clamping, result register. Depends on tgr_pkg, tgr_if, tgr_ctrl, tgr_tile_mem.
//
// Use: i_cfg writes face_width (index 0) and face_height (index 1), taken
// at any cycle its valid is high; write them only while no item is in work.
// i_in carries one operation per item; o_out returns exactly one result
// item for each, in order. The grid lives in two banks of one tile memory;
// turns copy the active bank into the other one tile per cycle through its
// single read and write port, and every operation ends with a one-tile-per-
// cycle scan that sets solved. One item is in work at a time. Reset clears
// the spin state and bank select and sets both sizes to 3; tiles are
// undefined until written or flooded. A finished result waits in the output
// register while the next item is already taken; a stalled receiver holds a
// later item in its final state until the register frees up.
module tile_grid_rotate_engine #(
    parameter int MAX_SIDE    = 16,
    parameter int COLOR_COUNT = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tgr_cfg_if.sink        i_cfg,
    tgr_in_if.sink         i_in,
    tgr_out_if.source      o_out
);

    localparam int ADDR_W = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int SIDE_W = tgr_pkg::SIDE_W;

    // size register value held within 1 to MAX_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        if (v == '0) return SIDE_W'(1);
        else if (int'(v) > MAX_SIDE) return SIDE_W'(MAX_SIDE);
        else return v;
    endfunction

    logic [SIDE_W-1:0]           r_face_w, r_face_h;
    logic                        r_out_valid;
    tgr_pkg::t_result            r_out;

    logic                        item_ready;
    logic                        res_valid;
    logic                        res_ready;
    tgr_pkg::t_result            res;
    tgr_pkg::t_item              item;
    logic                        wr_en, rd_en;
    logic [ADDR_W:0]             wr_addr, rd_addr;
    logic [tgr_pkg::COLOR_W-1:0] wr_data, rd_data;

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_w <= SIDE_W'(3);
            r_face_h <= SIDE_W'(3);
        end else if (i_cfg.valid) begin
            case (tgr_pkg::t_cfg_reg'(i_cfg.addr))
                tgr_pkg::REG_FACE_WIDTH:  r_face_w <= i_cfg.data;
                tgr_pkg::REG_FACE_HEIGHT: r_face_h <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input item unpacked from the channel
    assign item = '{op: tgr_pkg::t_op'(i_in.op), col: i_in.col, row: i_in.row,
                    color: i_in.color};
    assign i_in.ready = item_ready;

    tgr_ctrl #(
        .ADDR_W      (ADDR_W),
        .COLOR_COUNT (COLOR_COUNT)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_face_w     (clamp_side(r_face_w)),
        .i_face_h     (clamp_side(r_face_h)),
        .i_item_valid (i_in.valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    tgr_tile_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result register between the sequencer and the output channel
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) r_out <= res;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_color = r_out.read_color;
    assign o_out.solved     = r_out.solved;
    assign o_out.cur_width  = r_out.cur_width;
    assign o_out.cur_height = r_out.cur_height;
    assign o_out.status     = r_out.status;

endmodule

// ----- src/tgr_tile_mem.sv -----
// Two-bank tile memory: one write port, one read port, registered read data.
// Depends on tgr_pkg for the colour width.
module tgr_tile_mem #(
    parameter int ADDR_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [ADDR_W:0]             i_wr_addr,
    input  logic [tgr_pkg::COLOR_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [ADDR_W:0]             i_rd_addr,
    output logic [tgr_pkg::COLOR_W-1:0] o_rd_data
);

    localparam int DEPTH = 2 << ADDR_W;

    logic [tgr_pkg::COLOR_W-1:0] r_mem [DEPTH];
    logic [tgr_pkg::COLOR_W-1:0] r_rd_data;

    // bank select is the top address bit
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/tgr_ctrl.sv -----
// Operation sequencer: single tile access, flood, bank-to-bank turns and the
// uniformity scan. Depends on tgr_pkg; drives the ports of tgr_tile_mem.
module tgr_ctrl #(
    parameter int ADDR_W      = 8,
    parameter int COLOR_COUNT = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tgr_pkg::SIDE_W-1:0]  i_face_w,
    input  logic [tgr_pkg::SIDE_W-1:0]  i_face_h,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  tgr_pkg::t_item              i_item,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output tgr_pkg::t_result            o_res,
    output logic                        o_wr_en,
    output logic [ADDR_W:0]             o_wr_addr,
    output logic [tgr_pkg::COLOR_W-1:0] o_wr_data,
    output logic                        o_rd_en,
    output logic [ADDR_W:0]             o_rd_addr,
    input  logic [tgr_pkg::COLOR_W-1:0] i_rd_data
);

    localparam int CNT_W   = ADDR_W + 1;
    localparam int SIDE_W  = tgr_pkg::SIDE_W;
    localparam int AREA_W  = tgr_pkg::AREA_W;
    localparam int COLOR_W = tgr_pkg::COLOR_W;

    // colour reduced by at most three subtractions of COLOR_COUNT, one per colour bit
    function automatic logic [COLOR_W-1:0] color_mod(input logic [COLOR_W-1:0] c);
        logic [COLOR_W-1:0] v;
        v = c;
        for (int k = 0; k < COLOR_W; k++) begin
            if (int'(v) >= COLOR_COUNT) begin
                v = v - COLOR_W'(COLOR_COUNT);
            end
        end
        return v;
    endfunction

    tgr_pkg::t_state    r_state, n_state;
    logic               r_bank;
    logic               r_swap;
    tgr_pkg::t_item     r_item;
    logic [SIDE_W-1:0]  r_w, r_h;
    logic [CNT_W-1:0]   r_n;
    logic [ADDR_W-1:0]  r_idx;
    logic               r_status;
    logic [COLOR_W-1:0] r_rd;
    tgr_pkg::t_turn     r_kind;
    logic [SIDE_W-1:0]  r_nw;
    logic [CNT_W-1:0]   r_cnt;
    logic [SIDE_W-1:0]  r_col;
    logic [ADDR_W-1:0]  r_src;
    logic [ADDR_W-1:0]  r_base;
    logic               r_wr_pend;
    logic [ADDR_W-1:0]  r_wr_addr;
    logic               r_sc_pend;
    logic               r_sc_first;
    logic [COLOR_W-1:0] r_ref;
    logic               r_ok;

    logic [SIDE_W-1:0]  cur_w, cur_h;
    logic [AREA_W-1:0]  w_area;
    logic [AREA_W-1:0]  w_idx;
    logic               w_bad;
    logic               w_last;
    tgr_pkg::t_turn     w_kind;

    // current sizes after any spins
    assign cur_w = r_swap ? i_face_h : i_face_w;
    assign cur_h = r_swap ? i_face_w : i_face_h;

    // tile count and linear index of the addressed tile
    assign w_area = AREA_W'(r_w) * AREA_W'(r_h);
    assign w_idx  = AREA_W'(r_item.row - SIDE_W'(1)) * AREA_W'(r_w)
                  + AREA_W'(r_item.col - SIDE_W'(1));
    assign w_bad  = (r_item.col == '0) || (r_item.col > r_w)
                 || (r_item.row == '0) || (r_item.row > r_h);
    assign w_last = (r_cnt == r_n - CNT_W'(1));

    // turn kind: rotate on a non-square grid is a half turn
    always_comb begin
        case (r_item.op)
            tgr_pkg::OP_ROT_CW:   w_kind = (r_w == r_h) ? tgr_pkg::TURN_CW : tgr_pkg::TURN_HALF;
            tgr_pkg::OP_ROT_CCW:  w_kind = (r_w == r_h) ? tgr_pkg::TURN_CCW : tgr_pkg::TURN_HALF;
            tgr_pkg::OP_SPIN_CW:  w_kind = tgr_pkg::TURN_CW;
            tgr_pkg::OP_SPIN_CCW: w_kind = tgr_pkg::TURN_CCW;
            default:              w_kind = tgr_pkg::TURN_HALF;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tgr_pkg::ST_IDLE: begin
                if (i_item_valid) n_state = tgr_pkg::ST_SETUP;
            end
            tgr_pkg::ST_SETUP: begin
                case (r_item.op)
                    tgr_pkg::OP_WRITE, tgr_pkg::OP_READ: n_state = tgr_pkg::ST_ACCESS;
                    tgr_pkg::OP_FLOOD:                   n_state = tgr_pkg::ST_FLOOD;
                    tgr_pkg::OP_ROT_CW, tgr_pkg::OP_ROT_CCW,
                    tgr_pkg::OP_SPIN_CW, tgr_pkg::OP_SPIN_CCW:
                                                         n_state = tgr_pkg::ST_TURN_INIT;
                    default:                             n_state = tgr_pkg::ST_SCAN;
                endcase
            end
            tgr_pkg::ST_ACCESS: begin
                if (r_item.op == tgr_pkg::OP_READ && !r_status) n_state = tgr_pkg::ST_RD_WAIT;
                else n_state = tgr_pkg::ST_SCAN;
            end
            tgr_pkg::ST_RD_WAIT:   n_state = tgr_pkg::ST_SCAN;
            tgr_pkg::ST_FLOOD: begin
                if (w_last) n_state = tgr_pkg::ST_SCAN;
            end
            tgr_pkg::ST_TURN_INIT: n_state = tgr_pkg::ST_TURN;
            tgr_pkg::ST_TURN: begin
                if (w_last) n_state = tgr_pkg::ST_TURN_END;
            end
            tgr_pkg::ST_TURN_END:  n_state = tgr_pkg::ST_SCAN;
            tgr_pkg::ST_SCAN: begin
                if (w_last) n_state = tgr_pkg::ST_SCAN_END;
            end
            tgr_pkg::ST_SCAN_END:  n_state = tgr_pkg::ST_DONE;
            tgr_pkg::ST_DONE: begin
                if (i_res_ready) n_state = tgr_pkg::ST_IDLE;
            end
            default:               n_state = tgr_pkg::ST_IDLE;
        endcase
    end

    // handshake, result and memory port outputs
    always_comb begin
        o_item_ready = (r_state == tgr_pkg::ST_IDLE);
        o_res_valid  = (r_state == tgr_pkg::ST_DONE);
        o_res        = '{read_color: r_rd, solved: r_ok, cur_width: cur_w,
                         cur_height: cur_h, status: r_status};
        o_wr_en   = 1'b0;
        o_wr_addr = {r_bank, r_idx};
        o_wr_data = r_item.color;
        o_rd_en   = 1'b0;
        o_rd_addr = {r_bank, r_idx};
        case (r_state)
            tgr_pkg::ST_ACCESS: begin
                o_wr_en = (r_item.op == tgr_pkg::OP_WRITE) && !r_status;
                o_rd_en = (r_item.op == tgr_pkg::OP_READ) && !r_status;
            end
            tgr_pkg::ST_FLOOD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = {r_bank, r_cnt[ADDR_W-1:0]};
            end
            tgr_pkg::ST_TURN: begin
                o_rd_en   = 1'b1;
                o_rd_addr = {r_bank, r_src};
            end
            tgr_pkg::ST_SCAN: begin
                o_rd_en   = 1'b1;
                o_rd_addr = {r_bank, r_cnt[ADDR_W-1:0]};
            end
            default: begin
            end
        endcase
        // copy of a turned tile lands in the other bank in the cycle after its read
        if (r_wr_pend) begin
            o_wr_en   = 1'b1;
            o_wr_addr = {~r_bank, r_wr_addr};
            o_wr_data = i_rd_data;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tgr_pkg::ST_IDLE;
            r_bank    <= 1'b0;
            r_swap    <= 1'b0;
            r_wr_pend <= 1'b0;
            r_sc_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= (r_state == tgr_pkg::ST_TURN);
            r_sc_pend <= (r_state == tgr_pkg::ST_SCAN);
            if (r_state == tgr_pkg::ST_TURN_END) begin
                r_bank <= ~r_bank;
                if ((r_item.op == tgr_pkg::OP_SPIN_CW || r_item.op == tgr_pkg::OP_SPIN_CCW)
                    && (r_w != r_h)) begin
                    r_swap <= ~r_swap;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        // step counter restarts at each state change
        if (n_state != r_state) r_cnt <= '0;
        else r_cnt <= r_cnt + CNT_W'(1);

        r_wr_addr  <= r_cnt[ADDR_W-1:0];
        r_sc_first <= (r_cnt == '0);

        case (r_state)
            tgr_pkg::ST_IDLE: begin
                if (i_item_valid) begin
                    r_item <= '{op: i_item.op, col: i_item.col, row: i_item.row,
                                color: color_mod(i_item.color)};
                    r_w    <= cur_w;
                    r_h    <= cur_h;
                    r_rd   <= '0;
                end
            end
            tgr_pkg::ST_SETUP: begin
                r_n      <= CNT_W'(w_area);
                r_idx    <= ADDR_W'(w_idx);
                r_status <= (r_item.op == tgr_pkg::OP_WRITE || r_item.op == tgr_pkg::OP_READ)
                            && w_bad;
                r_kind   <= w_kind;
                r_nw     <= (w_kind == tgr_pkg::TURN_HALF) ? r_w : r_h;
            end
            tgr_pkg::ST_RD_WAIT: begin
                r_rd <= i_rd_data;
            end
            tgr_pkg::ST_TURN_INIT: begin
                // source of the first destination tile
                r_col <= '0;
                case (r_kind)
                    tgr_pkg::TURN_CW: begin
                        r_src  <= ADDR_W'(r_n - CNT_W'(r_w));
                        r_base <= ADDR_W'(r_n - CNT_W'(r_w));
                    end
                    tgr_pkg::TURN_CCW: begin
                        r_src  <= ADDR_W'(r_w - SIDE_W'(1));
                        r_base <= ADDR_W'(r_w - SIDE_W'(1));
                    end
                    default: begin
                        r_src  <= ADDR_W'(r_n - CNT_W'(1));
                        r_base <= ADDR_W'(r_n - CNT_W'(1));
                    end
                endcase
            end
            tgr_pkg::ST_TURN: begin
                if (r_col == r_nw - SIDE_W'(1)) begin
                    // next destination row
                    r_col <= '0;
                    case (r_kind)
                        tgr_pkg::TURN_CW: begin
                            r_base <= r_base + ADDR_W'(1);
                            r_src  <= r_base + ADDR_W'(1);
                        end
                        tgr_pkg::TURN_CCW: begin
                            r_base <= r_base - ADDR_W'(1);
                            r_src  <= r_base - ADDR_W'(1);
                        end
                        default: r_src <= r_src - ADDR_W'(1);
                    endcase
                end else begin
                    r_col <= r_col + SIDE_W'(1);
                    case (r_kind)
                        tgr_pkg::TURN_CW:  r_src <= r_src - ADDR_W'(r_w);
                        tgr_pkg::TURN_CCW: r_src <= r_src + ADDR_W'(r_w);
                        default:           r_src <= r_src - ADDR_W'(1);
                    endcase
                end
            end
            default: begin
            end
        endcase

        // uniformity check against the first tile
        if (r_sc_pend) begin
            if (r_sc_first) begin
                r_ref <= i_rd_data;
                r_ok  <= 1'b1;
            end else if (i_rd_data != r_ref) begin
                r_ok  <= 1'b0;
            end
        end
    end

endmodule

// ----- dv/tb_tile_grid_rotate_engine.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of tile_grid_rotate_engine: directed and random grid operations
// checked against a grid model kept in the bench. Depends on tgr_pkg and the tgr_if channels.
module tb_tile_grid_rotate_engine;
    import tgr_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int GRID_SIDE   = 16;
    localparam int BANK_TILES  = GRID_SIDE * GRID_SIDE;
    localparam int PALETTE     = 8;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 600;

    typedef struct {
        t_result want;
        t_op     op;
        int      seq;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tgr_cfg_if cfg_if ();
    tgr_in_if  in_if ();
    tgr_out_if out_if ();

    tile_grid_rotate_engine #(
        .MAX_SIDE    (GRID_SIDE),
        .COLOR_COUNT (PALETTE)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Grid model: two banks, written flags, bank select, spin state, sizes
    bit [COLOR_W-1:0] tile_mem [2][BANK_TILES];
    bit               tile_set [2][BANK_TILES];
    bit               cur_bank   = 1'b0;
    bit               spun       = 1'b0;
    bit [SIDE_W-1:0]  reg_width  = 5'd3;
    bit [SIDE_W-1:0]  reg_height = 5'd3;

    t_answer grid_answers [$];
    int      item_seq    = 0;
    int      fault_count = 0;
    int      cycle_count = 0;
    int      idle_pct    = 0;
    int      stall_pct   = 0;

    // Clock
    always begin
        #(HALF_PERIOD) i_clk = 1'b1;
        #(HALF_PERIOD) i_clk = 1'b0;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tile_grid_rotate_engine regression: fail");
            $finish;
        end
    end

    task automatic log_fault(string msg);
        $display("%0t FAULT: %s", $time, msg);
        fault_count++;
    endtask

    function automatic int fit_side(bit [SIDE_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID_SIDE) return GRID_SIDE;
        return int'(v);
    endfunction

    function automatic void grid_dims(output int w, output int h);
        int a, b;
        a = fit_side(reg_width);
        b = fit_side(reg_height);
        if (spun) begin
            w = b;
            h = a;
        end else begin
            w = a;
            h = b;
        end
    endfunction

    // Copy the active bank into the other one, turned; w and h are the sizes before
    function automatic void turn_tiles(t_turn kind, int w, int h);
        int nw, nh, src, dst;
        bit nb;
        nb = ~cur_bank;
        nw = (kind == TURN_HALF) ? w : h;
        nh = (kind == TURN_HALF) ? h : w;
        for (int r = 0; r < nh; r++) begin
            for (int c = 0; c < nw; c++) begin
                case (kind)
                    TURN_HALF: src = (h - 1 - r) * w + (w - 1 - c);
                    TURN_CW:   src = (h - 1 - c) * w + r;
                    default:   src = c * w + (w - 1 - r);
                endcase
                dst = r * nw + c;
                tile_mem[nb][dst] = tile_mem[cur_bank][src];
                tile_set[nb][dst] = tile_set[cur_bank][src];
            end
        end
        cur_bank = nb;
    endfunction

    function automatic bit grid_uniform(int n);
        for (int i = 0; i < n; i++)
            if (tile_mem[cur_bank][i] != tile_mem[cur_bank][0]) return 1'b0;
        return 1'b1;
    endfunction

    // True when every tile of the current grid holds a written colour
    function automatic bit grid_covered();
        int w, h;
        grid_dims(w, h);
        for (int i = 0; i < w * h; i++)
            if (!tile_set[cur_bank][i]) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one operation to the model and return the result it gives
    function automatic t_result grid_apply(t_op op, int col, int row, bit [COLOR_W-1:0] color);
        t_result res;
        int w, h, idx;
        t_turn kind;
        res = '0;
        grid_dims(w, h);
        case (op)
            OP_WRITE, OP_READ: begin
                if (col < 1 || col > w || row < 1 || row > h) begin
                    res.status = 1'b1;
                end else begin
                    idx = (row - 1) * w + (col - 1);
                    if (op == OP_WRITE) begin
                        tile_mem[cur_bank][idx] = int'(color) % PALETTE;
                        tile_set[cur_bank][idx] = 1'b1;
                    end else begin
                        res.read_color = tile_mem[cur_bank][idx];
                    end
                end
            end
            OP_FLOOD: begin
                for (int i = 0; i < w * h; i++) begin
                    tile_mem[cur_bank][i] = int'(color) % PALETTE;
                    tile_set[cur_bank][i] = 1'b1;
                end
            end
            OP_ROT_CW, OP_ROT_CCW: begin
                // non-square grids only allow the half turn
                if (w != h) kind = TURN_HALF;
                else if (op == OP_ROT_CW) kind = TURN_CW;
                else kind = TURN_CCW;
                turn_tiles(kind, w, h);
            end
            OP_SPIN_CW, OP_SPIN_CCW: begin
                turn_tiles((op == OP_SPIN_CW) ? TURN_CW : TURN_CCW, w, h);
                if (w != h) spun = ~spun;
            end
            default: ;
        endcase
        grid_dims(w, h);
        res.solved     = grid_uniform(w * h);
        res.cur_width  = w;
        res.cur_height = h;
        return res;
    endfunction

    // Send one item, then record the result it should produce
    task automatic send_item(t_op op, logic [SIDE_W-1:0] col, logic [SIDE_W-1:0] row,
                             logic [COLOR_W-1:0] color);
        t_answer ans;
        while ($urandom_range(99) < idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.op    <= op;
        in_if.col   <= col;
        in_if.row   <= row;
        in_if.color <= color;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        ans.want = grid_apply(op, col, row, color);
        ans.op   = op;
        ans.seq  = item_seq++;
        grid_answers.push_back(ans);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (grid_answers.size() != 0);
    endtask

    task automatic set_register(t_cfg_reg which, logic [SIDE_W-1:0] value);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= which;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid <= 1'b0;
        if (which == REG_FACE_WIDTH) reg_width = value;
        else reg_height = value;
    endtask

    // Flood first whenever the grid holds tiles never written
    task automatic ensure_covered();
        if (!grid_covered()) send_item(OP_FLOOD, 1, 1, $urandom_range(7));
    endtask

    task automatic send_random_item();
        int w, h, pick;
        t_op op;
        logic [SIDE_W-1:0] col, row;
        logic [COLOR_W-1:0] color;
        grid_dims(w, h);
        pick = $urandom_range(99);
        if (pick < 35) op = OP_WRITE;
        else if (pick < 60) op = OP_READ;
        else if (pick < 65) op = OP_FLOOD;
        else if (pick < 95) begin
            case (pick % 4)
                0:       op = OP_ROT_CW;
                1:       op = OP_ROT_CCW;
                2:       op = OP_SPIN_CW;
                default: op = OP_SPIN_CCW;
            endcase
        end else op = OP_SOLVED;
        // mostly in range, some anywhere in the field
        col = ($urandom_range(99) < 12) ? $urandom_range(31) : $urandom_range(w, 1);
        row = ($urandom_range(99) < 12) ? $urandom_range(31) : $urandom_range(h, 1);
        // half the colours match the first tile so uniform grids persist
        color = $urandom_range(1) ? tile_mem[cur_bank][0] : $urandom_range(7);
        send_item(op, col, row, color);
    endtask

    task automatic check_field(string field, logic [7:0] got, logic [7:0] want, t_answer ans);
        if (got !== want)
            log_fault($sformatf("item %0d (%s): %s is %0d, expected %0d",
                                ans.seq, ans.op.name(), field, got, want));
    endtask

    // Receiver: random stall and per-field check of each result item
    always @(posedge i_clk) begin
        t_answer ans;
        out_if.ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (grid_answers.size() == 0) begin
                log_fault("result item with no pending operation");
            end else begin
                ans = grid_answers.pop_front();
                check_field("read_color", out_if.read_color, ans.want.read_color, ans);
                check_field("solved",     out_if.solved,     ans.want.solved,     ans);
                check_field("cur_width",  out_if.cur_width,  ans.want.cur_width,  ans);
                check_field("cur_height", out_if.cur_height, ans.want.cur_height, ans);
                check_field("status",     out_if.status,     ans.want.status,     ans);
            end
        end
    end

    // Square 3x3 at reset sizes: every op, corners, bad coordinates
    task automatic test_square_ops();
        idle_pct  = 0;
        stall_pct = 0;
        send_item(OP_FLOOD, 1, 1, 7);
        send_item(OP_SOLVED, 0, 0, 0);
        send_item(OP_WRITE, 1, 1, 0);
        send_item(OP_WRITE, 3, 3, 5);
        send_item(OP_WRITE, 2, 1, 2);
        send_item(OP_READ, 3, 3, 0);
        send_item(OP_ROT_CW, 0, 0, 0);
        send_item(OP_READ, 1, 1, 0);
        send_item(OP_READ, 3, 1, 0);
        send_item(OP_ROT_CCW, 31, 31, 7);
        send_item(OP_SPIN_CW, 0, 0, 0);
        send_item(OP_READ, 3, 1, 0);
        send_item(OP_SPIN_CCW, 0, 0, 0);
        send_item(OP_SOLVED, 31, 31, 7);
        send_item(OP_WRITE, 0, 2, 3);
        send_item(OP_READ, 2, 0, 0);
        send_item(OP_WRITE, 4, 1, 3);
        send_item(OP_READ, 1, 4, 0);
        send_item(OP_READ, 31, 31, 0);
        send_item(OP_WRITE, 31, 1, 6);
        send_item(OP_READ, 2, 1, 0);
    endtask

    // 4x2 grid: rotates give the half turn, spins swap the sizes
    task automatic test_nonsquare_turns();
        set_register(REG_FACE_WIDTH, 4);
        set_register(REG_FACE_HEIGHT, 2);
        idle_pct  = 30;
        stall_pct = 30;
        send_item(OP_FLOOD, 1, 1, 0);
        send_item(OP_WRITE, 1, 1, 1);
        send_item(OP_WRITE, 4, 1, 2);
        send_item(OP_WRITE, 1, 2, 3);
        send_item(OP_WRITE, 4, 2, 4);
        send_item(OP_ROT_CW, 0, 0, 0);
        send_item(OP_READ, 1, 1, 0);
        send_item(OP_ROT_CCW, 0, 0, 0);
        send_item(OP_SPIN_CW, 0, 0, 0);
        send_item(OP_READ, 2, 1, 0);
        send_item(OP_READ, 1, 4, 0);
        send_item(OP_READ, 3, 1, 0);
        send_item(OP_SPIN_CCW, 0, 0, 0);
        send_item(OP_READ, 4, 1, 0);
    endtask

    // Sizes 0 and 31 clamp; a shrink keeps the stored tiles
    task automatic test_register_edges();
        set_register(REG_FACE_WIDTH, 0);
        set_register(REG_FACE_HEIGHT, 31);
        idle_pct  = 65;
        stall_pct = 65;
        ensure_covered();
        send_item(OP_WRITE, 1, 16, 6);
        send_item(OP_READ, 1, 16, 0);
        send_item(OP_READ, 2, 1, 0);
        send_item(OP_SPIN_CW, 0, 0, 0);
        send_item(OP_READ, 16, 1, 0);
        send_item(OP_SOLVED, 0, 0, 0);
        set_register(REG_FACE_WIDTH, 31);
        ensure_covered();
        send_item(OP_WRITE, 16, 16, 0);
        send_item(OP_READ, 16, 16, 0);
        send_item(OP_WRITE, 17, 16, 1);
        send_item(OP_ROT_CW, 0, 0, 0);
        send_item(OP_READ, 1, 16, 0);
        send_item(OP_SPIN_CCW, 0, 0, 0);
        set_register(REG_FACE_WIDTH, 2);
        set_register(REG_FACE_HEIGHT, 2);
        send_item(OP_READ, 2, 2, 0);
        send_item(OP_READ, 1, 1, 0);
        send_item(OP_SOLVED, 0, 0, 0);
    endtask

    task automatic run_random_phase(int w, int h, int items, int idle, int stall);
        set_register(REG_FACE_WIDTH, w);
        set_register(REG_FACE_HEIGHT, h);
        idle_pct  = idle;
        stall_pct = stall;
        ensure_covered();
        repeat (items) send_random_item();
    endtask

    // Random operations over a range of grid sizes, idling and stall patterns
    task automatic test_random_mix();
        run_random_phase(3, 3, 120, 0, 0);
        run_random_phase(5, 5, 100, 65, 0);
        run_random_phase(4, 7, 100, 0, 65);
        run_random_phase(16, 16, 25, 30, 30);
        run_random_phase(2, 9, 100, 30, 30);
        run_random_phase(1, 1, 40, 0, 0);
        run_random_phase(16, 1, 50, 65, 0);
        run_random_phase(1, 16, 50, 0, 65);
        run_random_phase(8, 8, 80, 30, 30);
        run_random_phase(6, 3, 85, 0, 0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        in_if.valid  = 1'b0;
        in_if.op     = OP_WRITE;
        in_if.col    = '0;
        in_if.row    = '0;
        in_if.color  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.addr  = REG_FACE_WIDTH;
        cfg_if.data  = '0;
        out_if.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_square_ops();
        test_nonsquare_turns();
        test_register_edges();
        test_random_mix();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (grid_answers.size() != 0)
            log_fault($sformatf("%0d result items never arrived", grid_answers.size()));
        if (fault_count == 0)
            $display("tile_grid_rotate_engine regression: pass");
        else
            $display("tile_grid_rotate_engine regression: fail");
        $finish;
    end

endmodule
